### hdl/brc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_pkg: shared types and constants for the byte recurrence checksum
// Widths, recurrence constants and the recurrence state record.
// ----------------------------------------------------------------------------
package brc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValW   = 16;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CoefW  = ByteW + 1;          // byte + alpha
  localparam int unsigned ProdW  = CoefW + ValW;       // widest product
  localparam int unsigned FoldW  = ValW + 1;           // hi + lo of a product

  localparam logic [ByteW-1:0] FirstOffset = 8'd7;
  localparam logic [PosW-1:0]  AlphaStep   = 8'd17;
  localparam logic [PosW-1:0]  BetaStep    = 8'd31;
  localparam logic [FoldW-1:0] FoldMod     = 17'd65535;

  typedef struct packed {
    logic [ValW-1:0] prev_value;
    logic [ValW-1:0] cur_value;
    logic [PosW-1:0] position_low;
    logic            at_first_byte;
  } brc_state_t;

  localparam brc_state_t RearmState = '{
    prev_value:    16'd1,
    cur_value:     16'd0,
    position_low:  8'd0,
    at_first_byte: 1'b1
  };

endpackage : brc_pkg

### hdl/brc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_in_if: byte input channel
// Valid/ready channel carrying one stream byte and its last mark per beat.
// ----------------------------------------------------------------------------
interface brc_in_if;
  logic                        valid;
  logic                        ready;
  logic [brc_pkg::ByteW-1:0]   data_byte;
  logic                        last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface : brc_in_if

### hdl/brc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_out_if: checksum output channel
// Valid/ready channel carrying one 16-bit checksum per beat.
// ----------------------------------------------------------------------------
interface brc_out_if;
  logic                      valid;
  logic                      ready;
  logic [brc_pkg::ValW-1:0]  checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface : brc_out_if

### hdl/brc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_step: one step of the recurrence
// Combinational next state from the current state and one byte.
// ----------------------------------------------------------------------------
module brc_step (
  input  brc_pkg::brc_state_t          state_i,
  input  logic [brc_pkg::ByteW-1:0]    data_byte_i,
  output brc_pkg::brc_state_t          state_o
);
  import brc_pkg::*;

  logic [PosW-1:0]  alpha;
  logic [PosW-1:0]  beta;
  logic [CoefW-1:0] coef_a;
  logic [ProdW-1:0] prod_a;
  logic [ProdW-1:0] prod_b;
  logic             a_ge_b;
  logic [ProdW-1:0] mag;
  logic [FoldW-1:0] fold_sum;
  logic [ValW-1:0]  mag_mod;
  logic [ValW-1:0]  next_val;

  // coefficients mod 256 are just the low byte of the product
  assign alpha  = PosW'(state_i.position_low * AlphaStep);
  assign beta   = PosW'(state_i.position_low * BetaStep);
  assign coef_a = CoefW'(data_byte_i) + CoefW'(alpha);

  assign prod_a = ProdW'(coef_a) * ProdW'(state_i.cur_value);
  assign prod_b = ProdW'(beta) * ProdW'(state_i.prev_value);

  assign a_ge_b = (prod_a >= prod_b);
  assign mag    = a_ge_b ? (prod_a - prod_b) : (prod_b - prod_a);

  // 2^16 == 1 mod 65535: fold high part onto low, then one subtract
  assign fold_sum = FoldW'(mag[ProdW-1:ValW]) + FoldW'(mag[ValW-1:0]);
  assign mag_mod  = (fold_sum >= FoldMod) ? ValW'(fold_sum - FoldMod)
                                          : ValW'(fold_sum);

  // negative difference wraps through 2^64 == 1: result is (1 - |d|) mod 65535
  always_comb begin
    if (a_ge_b) begin
      next_val = mag_mod;
    end else if (mag_mod == '0) begin
      next_val = ValW'(1);
    end else if (mag_mod == ValW'(1)) begin
      next_val = '0;
    end else begin
      next_val = ValW'(0) - mag_mod;
    end
  end

  always_comb begin
    if (state_i.at_first_byte) begin
      state_o.prev_value    = ValW'(1);
      state_o.cur_value     = ValW'(data_byte_i) + ValW'(FirstOffset);
      state_o.position_low  = PosW'(1);
      state_o.at_first_byte = 1'b0;
    end else begin
      state_o.prev_value    = state_i.cur_value;
      state_o.cur_value     = next_val;
      state_o.position_low  = state_i.position_low + PosW'(1);
      state_o.at_first_byte = 1'b0;
    end
  end

endmodule : brc_step

### hdl/byte_recurrence_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_recurrence_checksum: second-order recurrence checksum over a byte stream
// Folds each stream into a 16-bit value mod 65535, one byte per beat.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : one stream byte per beat, last marks the final byte of a stream.
//   out_o : one checksum beat per stream, issued for the beat marked last.
//   A beat is taken whenever valid and ready are both high.
// Path: a byte lands in the input register at the edge it is taken; it is
//   then consumed by the recurrence step and, for a last byte, the result
//   loads the output register, from which the checksum is offered.
// Throughput: one byte per cycle unless a last byte waits on a pending checksum,
//   set by the combinational recurrence step (two 9x16/8x16 products,
//   compare-subtract, mod-65535 fold) that feeds the state registers directly.
// Reset: state returns to prev=1, cur=0, position 0, expecting a first byte;
//   both registers are emptied. The same rearm happens after each last byte.
// Stall: while a checksum waits on out_o, bytes that are not last still flow
//   through; a last byte waits in the input register, which then drops
//   in_i.ready until the pending checksum is taken.
// ----------------------------------------------------------------------------
module byte_recurrence_checksum (
  input  logic       clk_i,
  input  logic       rst_ni,
  brc_in_if.sink     in_i,
  brc_out_if.source  out_o
);
  import brc_pkg::*;

  // input register
  logic             in_v_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // recurrence state
  brc_state_t       st_q, st_d;
  brc_state_t       st_step;

  // output register
  logic             out_v_q;
  logic [ValW-1:0]  out_sum_q;

  logic             consume;
  logic             in_take;

  // a last byte needs a free (or freeing) output slot
  assign consume = in_v_q && (!in_last_q || !out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || consume;
  assign in_take = in_i.valid && in_i.ready;

  brc_step u_step (
    .state_i     (st_q),
    .data_byte_i (in_byte_q),
    .state_o     (st_step)
  );

  always_comb begin
    st_d = st_q;
    if (consume) begin
      st_d = in_last_q ? RearmState : st_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      st_q    <= RearmState;
    end else begin
      st_q <= st_d;
      if (in_take) begin
        in_v_q <= 1'b1;
      end else if (consume) begin
        in_v_q <= 1'b0;
      end
      if (consume && in_last_q) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last;
    end
    if (consume && in_last_q) begin
      out_sum_q <= st_step.cur_value;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.checksum = out_sum_q;

  // checks
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_sum_q != 16'hFFFF))
    else $error("checksum outside 0..65534");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_last_q) |=> st_q.at_first_byte)
    else $error("state not rearmed after last byte");

  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !consume) |=> (in_v_q && $stable(in_byte_q) && $stable(in_last_q)))
    else $error("held input byte lost or changed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready) |=> (out_v_q && $stable(out_sum_q)))
    else $error("pending checksum overwritten");

endmodule : byte_recurrence_checksum

### verif/brc_checksum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_checksum_checker: predicts and checks the recurrence checksum
// Watches both channels. Every byte beat runs the recurrence on a local copy
// of the state, every last byte queues the checksum due, and every output
// beat is compared with the oldest queued checksum.
// ----------------------------------------------------------------------------
module brc_checksum_checker
  import brc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  brc_in_if           in_mon_i,
  brc_out_if          out_mon_i,
  output int unsigned err_cnt_o,
  output int unsigned pend_cnt_o,
  output int unsigned bytes_seen_o,
  output int unsigned sums_checked_o
);

  localparam int unsigned ShowLimit = 10;

  brc_state_t       rec_state;
  logic [ValW-1:0]  due_sums[$];

  // One recurrence step on one byte.
  function automatic brc_state_t fold_byte(brc_state_t s, logic [ByteW-1:0] b);
    logic [PosW-1:0] alpha;
    logic [PosW-1:0] beta;
    logic [63:0]     lhs;
    logic [63:0]     rhs;
    logic [63:0]     diff;
    brc_state_t      n;
    if (s.at_first_byte) begin
      n.prev_value    = 16'd1;
      n.cur_value     = ValW'(b) + ValW'(FirstOffset);
      n.position_low  = 8'd1;
      n.at_first_byte = 1'b0;
    end else begin
      // 8-bit context: both coefficients are taken mod 256
      alpha = s.position_low * AlphaStep;
      beta  = s.position_low * BetaStep;
      lhs   = (64'(b) + 64'(alpha)) * 64'(s.cur_value);
      rhs   = 64'(beta) * 64'(s.prev_value);
      // 64-bit wrap first, then the fold, as a negative difference demands
      diff  = lhs - rhs;
      n.prev_value    = s.cur_value;
      n.cur_value     = ValW'(diff % 64'(FoldMod));
      n.position_low  = s.position_low + 8'd1;
      n.at_first_byte = 1'b0;
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_state      <= RearmState;
      due_sums.delete();
      err_cnt_o      <= 0;
      pend_cnt_o     <= 0;
      bytes_seen_o   <= 0;
      sums_checked_o <= 0;
    end else begin
      // output side first: a checksum never leaves in the beat of its byte
      if (out_mon_i.valid && out_mon_i.ready) begin
        sums_checked_o <= sums_checked_o + 1;
        if (due_sums.size() == 0) begin
          if (err_cnt_o < ShowLimit)
            $display("%0t: checksum %0d arrived with none due", $realtime,
                     out_mon_i.checksum);
          err_cnt_o <= err_cnt_o + 1;
        end else if (out_mon_i.checksum !== due_sums[0]) begin
          if (err_cnt_o < ShowLimit)
            $display("%0t: checksum mismatch, expected %0d got %0d", $realtime,
                     due_sums[0], out_mon_i.checksum);
          err_cnt_o <= err_cnt_o + 1;
          void'(due_sums.pop_front());
        end else begin
          void'(due_sums.pop_front());
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        brc_state_t nxt;
        nxt = fold_byte(rec_state, in_mon_i.data_byte);
        bytes_seen_o <= bytes_seen_o + 1;
        if (in_mon_i.last) begin
          due_sums.push_back(nxt.cur_value);
          rec_state <= RearmState;
        end else begin
          rec_state <= nxt;
        end
      end
      pend_cnt_o <= due_sums.size();
    end
  end

endmodule : brc_checksum_checker

### verif/tb_byte_recurrence_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_recurrence_checksum: stimulus and verdict for the checksum block
// Sends directed streams (single bytes, extreme bytes, a run that ends on a
// low coefficient step) and then random streams of mixed length, long ones
// wrapping the position, under four idling regimes. A side checker predicts
// and compares every checksum beat.
// ----------------------------------------------------------------------------
module tb_byte_recurrence_checksum;

  import brc_pkg::*;

  // Cycles without any beat on either channel before the run is called hung.
  // Far above the longest gap the 70 % idling can plausibly produce.
  localparam int unsigned HangLimit   = 1000;
  // Settling margin after the last due checksum has been taken.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 475;
  localparam int unsigned NumPhases   = 4;

  logic clk_i;
  logic rst_ni;

  brc_in_if  in_ch ();
  brc_out_if out_ch ();

  int unsigned err_cnt;
  int unsigned pend_cnt;
  int unsigned bytes_seen;
  int unsigned sums_checked;

  // Idling controls, changed per phase by the stimulus process.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned streams_sent;
  int unsigned hang_cnt = 0;

  // Per-phase idling: none, sender only, receiver only, both lightly.
  int unsigned idle_tab[NumPhases]  = '{0, 70, 0, 15};
  int unsigned stall_tab[NumPhases] = '{0, 0, 70, 15};

  byte_recurrence_checksum u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  brc_checksum_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon_i       (in_ch),
    .out_mon_i      (out_ch),
    .err_cnt_o      (err_cnt),
    .pend_cnt_o     (pend_cnt),
    .bytes_seen_o   (bytes_seen),
    .sums_checked_o (sums_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: ready redrawn every cycle from the current stall rate, so
  // stalls land on any cycle of the output register's life.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any beat resets the count; a long silence ends the run.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      hang_cnt <= 0;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
    if (hang_cnt >= HangLimit) begin
      $display("%0t: no beat for %0d cycles, %0d checksums still due", $realtime,
               HangLimit, pend_cnt);
      $display("tb_byte_recurrence_checksum NOT OK");
      $finish;
    end
  end

  // One byte beat. Optional idle cycles first, then valid held until taken.
  // Valid is only raised or lowered once per edge, never both.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Random byte, leaning on the two extremes now and then.
  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ByteW'($urandom_range(255));
  endfunction

  // Whole stream of random content of the given length; counts it as sent.
  task automatic send_stream(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_byte(pick_byte(), k == len - 1);
    streams_sent++;
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned len;
    int unsigned r;

    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    streams_sent    = 0;
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last      <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---------------------------------------------------------
    // One-byte streams at both byte extremes: checksum is just byte + 7.
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    // Two-byte streams at both extremes, back to back, so the rearm after
    // each last byte is exercised too.
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // Seventeen bytes: position 16 has alpha 16 against beta 240, so a zero
    // byte there almost surely drives the difference negative.
    for (int unsigned k = 0; k < 16; k++) send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    streams_sent += 5;

    // --- random, phase by phase -------------------------------------------
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      // Each phase opens with one stream long enough to wrap the position.
      len = $urandom_range(520, 257);
      send_stream(len);
      phase_items = len;
      while (phase_items < PhaseItems) begin
        r = $urandom_range(99);
        if (r < 20)       len = $urandom_range(2, 1);
        else if (r < 90)  len = $urandom_range(24, 3);
        else              len = $urandom_range(80, 25);
        send_stream(len);
        phase_items += len;
      end
    end
    in_ch.valid <= 1'b0;

    // --- drain and verdict ------------------------------------------------
    // one edge first so the checker's count includes the final last byte
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d streams over %0d idling phases;", bytes_seen,
             streams_sent, NumPhases);
    $display("%0d checksums compared, %0d mismatches, %0d still due.", sums_checked,
             err_cnt, pend_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("tb_byte_recurrence_checksum OK");
    end else begin
      $display("tb_byte_recurrence_checksum NOT OK");
    end
    $finish;
  end

endmodule : tb_byte_recurrence_checksum
